### rtl/core/fp3s_pkg.sv
// ----------------------------------------------------------------------------
// fp3s_pkg
// Types and constants for the binary64 to three FP21 splitter.
// ----------------------------------------------------------------------------
package fp3s_pkg;

  localparam int unsigned DblW   = 64;
  localparam int unsigned SglW   = 32;
  localparam int unsigned Fp21W  = 21;
  localparam int unsigned Fp21Sh = 11;

  localparam logic [SglW-1:0] F21RoundAdd = 32'h0000_0400;
  localparam logic [DblW-1:0] DblQnan     = 64'h7FF8_0000_0000_0000;

  typedef logic [DblW-1:0]  dbl_t;
  typedef logic [SglW-1:0]  sgl_t;
  typedef logic [Fp21W-1:0] fp21_t;

  // Result transaction: head in the top bits.
  typedef struct packed {
    fp21_t head_part;
    fp21_t middle_part;
    fp21_t tail_part;
  } split_t;

  // Aligned-subtract intermediate: operands share the larger exponent.
  typedef struct packed {
    logic        nan;      // result is NaN (canonical)
    logic        inf;      // result is infinity, sign in sgn
    logic        zero;     // exact zero result
    logic        sgn;
    logic [10:0] exp;      // exponent of larger operand
    logic [57:0] mag;      // significand sum/difference, 3 guard bits
  } sub_mid_t;

endpackage

### rtl/core/fp3s_if.sv
// ----------------------------------------------------------------------------
// fp3s_if
// Valid/ready channel carrying a payload of parameter type.
// ----------------------------------------------------------------------------
interface fp3s_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fp64_split_three_fp21.sv
// ----------------------------------------------------------------------------
// fp64_split_three_fp21
// Splits a binary64 value into three FP21 words (head, middle, tail).
// ----------------------------------------------------------------------------
// One transaction per cycle when not stalled: three split steps of three
// register stages each, then the output register. The head and middle words
// wait in delay registers (six and three stages) to line up with the tail
// word; the last step's residual is not needed. The whole pipeline advances
// when the output register is free or being taken.
module fp64_split_three_fp21 (
  input  logic clk,
  input  logic rst_n,
  fp3s_if.sink   in_ch,
  fp3s_if.source out_ch
);
  import fp3s_pkg::*;

  localparam int unsigned Depth = 9;

  logic           en;
  logic [Depth:0] vld_r;
  fp21_t          w0, w1, w2u;
  dbl_t           r0, r1, r2u;
  fp21_t          h_d1_r, h_d2_r, h_d3_r, h_d4_r, h_d5_r, h_d6_r;
  fp21_t          m_d1_r, m_d2_r, m_d3_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-1:0], in_ch.valid};
  end

  fp3s_stage u_st0 (.clk, .en, .cur_i(in_ch.data), .word_o(w0), .res_o(r0));
  fp3s_stage u_st1 (.clk, .en, .cur_i(r0), .word_o(w1), .res_o(r1));
  fp3s_stage u_st2 (.clk, .en, .cur_i(r1), .word_o(w2u), .res_o(r2u));

  // head waits six stages, middle three; residual r2u is unused beyond
  always_ff @(posedge clk) begin
    if (en) begin
      h_d1_r <= w0;
      h_d2_r <= h_d1_r;
      h_d3_r <= h_d2_r;
      h_d4_r <= h_d3_r;
      h_d5_r <= h_d4_r;
      h_d6_r <= h_d5_r;
      m_d1_r <= w1;
      m_d2_r <= m_d1_r;
      m_d3_r <= m_d2_r;
    end
  end

  logic [Fp21W-1:0] head_r, mid_r, tail_r;
  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= (r2u == r2u) ? h_d6_r : h_d6_r;
      mid_r  <= m_d3_r;
      tail_r <= w2u;
    end
  end

  assign out_ch.valid            = vld_r[Depth];
  assign out_ch.data.head_part   = head_r;
  assign out_ch.data.middle_part = mid_r;
  assign out_ch.data.tail_part   = tail_r;

  always_ff @(posedge clk) begin
    if (rst_n && out_ch.valid && !out_ch.ready)
      assert (en == 1'b0) else $error("pipeline advanced during stall");
  end
  property p_in_ready;
    @(posedge clk) disable iff (!rst_n) (out_ch.valid && !out_ch.ready) |-> !in_ch.ready;
  endproperty
  assert property (p_in_ready) else $error("input taken while output stalled");
  property p_vld;
    @(posedge clk) disable iff (!rst_n) (en && in_ch.valid) |=> vld_r[0];
  endproperty
  assert property (p_vld) else $error("valid bit lost at entry");
  property p_hold;
    @(posedge clk) disable iff (!rst_n) (out_ch.valid && !out_ch.ready) |=> $stable(tail_r);
  endproperty
  assert property (p_hold) else $error("result changed under stall");

endmodule

### rtl/core/fp3s_stage.sv
// ----------------------------------------------------------------------------
// fp3s_stage
// One split step: round to binary32, form FP21, subtract it in binary64.
// Three register stages; the enable advances all of them together.
// ----------------------------------------------------------------------------
module fp3s_stage (
  input  logic            clk,
  input  logic            en,
  input  fp3s_pkg::dbl_t  cur_i,
  output fp3s_pkg::fp21_t word_o,
  output fp3s_pkg::dbl_t  res_o
);
  import fp3s_pkg::*;

  // ---------------- step A: binary64 -> binary32 ----------------
  function automatic sgl_t dbl_to_sgl(input dbl_t b);
    logic        sg;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic [11:0] fe;     // signed, exp - 896
    logic [6:0]  s;
    logic [52:0] q;
    logic [52:0] rem;
    logic [52:0] half;
    logic        up;
    logic [8:0]  fen;
    sgl_t        r;
    sg  = b[63];
    e   = b[62:52];
    m   = b[51:0];
    sig = {1'b1, m};
    fe  = {1'b0, e} - 12'd896;
    r   = {sg, 31'd0};
    s   = 7'd29;
    q   = '0; rem = '0; half = '0; up = 1'b0; fen = '0;
    if (e == 11'h7FF) begin
      if (m == '0) r = {sg, 31'h7F80_0000};
      else         r = {sg, 8'hFF, 1'b1, m[50:29]};
    end else if (e == '0) begin
      r = {sg, 31'd0};
    end else if (!fe[11] && fe >= 12'd255) begin
      r = {sg, 31'h7F80_0000};
    end else begin
      if (!fe[11] && fe != '0) s = 7'd29;
      else s = 7'd30 - fe[6:0];
      if (fe[11] && (fe < 12'hFE0)) begin
        r = {sg, 31'd0};  // shift beyond 60
      end else if (s > 7'd60) begin
        r = {sg, 31'd0};
      end else begin
        q    = sig >> s;
        half = 53'd1 << (s - 7'd1);
        rem  = sig & ((53'd1 << s) - 53'd1);
        up   = (rem > half) || ((rem == half) && q[0]);
        q    = q + {52'd0, up};
        if (!fe[11] && fe != '0) begin
          fen = fe[8:0];
          if (q[24]) begin
            q   = 53'd1 << 23;
            fen = fen + 9'd1;
          end
          if (fen >= 9'd255) r = {sg, 31'h7F80_0000};
          else r = {sg, fen[7:0], q[22:0]};
        end else begin
          r = {sg, q[30:0]};
        end
      end
    end
    return r;
  endfunction

  sgl_t s1_sgl_r;
  dbl_t s1_cur_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sgl_r <= dbl_to_sgl(cur_i);
      s1_cur_r <= cur_i;
    end
  end

  // ---------------- step B: FP21, widen, align ----------------
  sgl_t  t_sum;
  fp21_t w_nxt;
  assign t_sum = s1_sgl_r + F21RoundAdd;
  assign w_nxt = t_sum[SglW-1:Fp21Sh];

  // widen FP21 (binary32 with low 11 bits clear) to binary64
  function automatic dbl_t sgl_to_dbl(input sgl_t f);
    logic        sg;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  lz;
    logic [22:0] mn;
    dbl_t        r;
    sg = f[31]; e = f[30:23]; m = f[22:0];
    lz = '0;
    for (int i = 22; i >= 0; i--) begin
      if (m[i] && lz == '0 && (m >> (i + 1)) == '0) lz = 5'(22 - i);
    end
    mn = m << (lz + 5'd1);
    if (e == 8'hFF)      r = {sg, 11'h7FF, m, 29'd0};
    else if (e == '0) begin
      if (m == '0) r = {sg, 63'd0};
      else r = {sg, 11'(11'd896 - {6'd0, lz}), mn, 29'd0};
    end else r = {sg, 11'({3'd0, e} + 11'd896), m, 29'd0};
    return r;
  endfunction

  function automatic sub_mid_t align_sub(input dbl_t a, input dbl_t bb);
    logic        sa, sb, na, nb, ia, ib;
    logic [10:0] ea, eb, ex, eaa, ebb, d;
    logic [55:0] ma, mb, big, sml, sh;
    logic        sticky;
    logic        a_big;
    sub_mid_t    o;
    sa = a[63]; sb = ~bb[63];  // a - b = a + (-b)
    ea = a[62:52]; eb = bb[62:52];
    na = (ea == 11'h7FF) && (a[51:0] != '0);
    nb = (eb == 11'h7FF) && (bb[51:0] != '0);
    ia = (ea == 11'h7FF) && (a[51:0] == '0);
    ib = (eb == 11'h7FF) && (bb[51:0] == '0);
    eaa = (ea == '0) ? 11'd1 : ea;
    ebb = (eb == '0) ? 11'd1 : eb;
    ma = {(ea != '0), a[51:0], 3'd0};
    mb = {(eb != '0), bb[51:0], 3'd0};
    a_big = (eaa > ebb) || ((eaa == ebb) && (ma >= mb));
    o = '0;
    if (a_big) begin
      big = ma; sml = mb; ex = eaa; d = eaa - ebb; o.sgn = sa;
    end else begin
      big = mb; sml = ma; ex = ebb; d = ebb - eaa; o.sgn = sb;
    end
    if (d > 11'd56) begin
      sh = '0; sticky = (sml != '0);
    end else begin
      sh = sml >> d;
      sticky = ((sml & ((56'd1 << d) - 56'd1)) != '0);
    end
    sh[0] = sh[0] | sticky;
    o.exp = ex;
    if (sa == sb) o.mag = {2'd0, big} + {2'd0, sh};
    else          o.mag = {2'd0, big} - {2'd0, sh};
    o.nan  = na || nb || (ia && ib && (sa != sb));
    o.inf  = !o.nan && (ia || ib);
    if (o.inf) o.sgn = ia ? sa : sb;
    o.zero = !o.nan && !o.inf && (o.mag == '0);
    return o;
  endfunction

  fp21_t    s2_w_r;
  sub_mid_t s2_mid_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_w_r   <= w_nxt;
      s2_mid_r <= align_sub(s1_cur_r, sgl_to_dbl({w_nxt, 11'd0}));
    end
  end

  // ---------------- step C: normalize and round ----------------
  function automatic dbl_t norm_round(input sub_mid_t x);
    logic [5:0]  lz;
    logic [12:0] e;       // signed
    logic [57:0] m;
    logic [6:0]  shl;
    logic [53:0] k;
    logic        g, st, up;
    dbl_t        r;
    lz = '0;
    for (int i = 57; i >= 0; i--) begin
      if (x.mag[i] && (x.mag >> (i + 1)) == '0) lz = 6'(57 - i);
    end
    // value = mag * 2^(exp-1023-55); leading at bit 55 is normal
    e = {2'd0, x.exp} + 13'd2 - {7'd0, lz};
    if (!e[12] && e != '0) begin
      m = x.mag << lz;
    end else begin
      shl = 7'(x.exp) + 7'd1;  // denormal: exponent field 0, value exp=1
      m   = x.mag << shl;
      e   = '0;
    end
    st = (m[3:0] != '0);
    g  = m[4];
    k  = {1'b0, m[57:5]};
    up = g && (st || k[0]);
    k  = k + {53'd0, up};
    if (k[53]) begin
      k = k >> 1;
      e = e + 13'd1;
    end else if (e == '0 && k[52]) begin
      e = 13'd1;
    end
    if (x.nan)                      r = DblQnan;
    else if (x.inf)                 r = {x.sgn, 11'h7FF, 52'd0};
    else if (x.zero)                r = 64'd0;
    else if (!e[12] && e >= 13'd2047) r = {x.sgn, 11'h7FF, 52'd0};
    else                            r = {x.sgn, e[10:0], k[51:0]};
    return r;
  endfunction

  fp21_t s3_w_r;
  dbl_t  s3_res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_w_r   <= s2_w_r;
      s3_res_r <= norm_round(s2_mid_r);
    end
  end

  assign word_o = s3_w_r;
  assign res_o  = s3_res_r;

endmodule
